// ----- rtl/dlfpl_pkg.sv -----
// ---------------------------------------------------------------------------
// dlfpl_pkg
// Shared types, constants and helpers of the doubly linked free page list.
// ---------------------------------------------------------------------------
`default_nettype none

package dlfpl_pkg;

    localparam int PAGES   = 1024;
    localparam int ID_W    = 10;
    localparam int PAGE_AW = (PAGES > 1) ? $clog2(PAGES) : 1;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    typedef logic [ID_W-1:0]    t_id;
    typedef logic [PAGE_AW-1:0] t_addr;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_INS1,
        OP_INS2,
        OP_RM_RD,
        OP_RM_LINK,
        OP_RM_CLR,
        OP_SKIP
    } t_op;

    typedef struct packed {
        logic load;
        logic finish;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic id_ok;
        logic kind;
    } t_sts;

    function automatic logic in_range(input t_id id);
        return 32'(id) < 32'(PAGES);
    endfunction

    function automatic t_addr id_to_addr(input t_id id);
        logic [PAGE_AW+ID_W-1:0] w;
        w = (PAGE_AW + ID_W)'(id);
        return w[PAGE_AW-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/dlfpl_ram.sv -----
// ---------------------------------------------------------------------------
// dlfpl_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module dlfpl_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  wire                             i_clk,
    input  wire                             i_we,
    input  wire  [$clog2(DEPTH)-1:0]        i_waddr,
    input  wire  [WIDTH-1:0]                i_wdata,
    input  wire                             i_re,
    input  wire  [$clog2(DEPTH)-1:0]        i_raddr,
    output logic [WIDTH-1:0]                o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/dlfpl_datapath.sv -----
// ---------------------------------------------------------------------------
// dlfpl_datapath
// Link tables, head and null id registers, and the registered result.
// ---------------------------------------------------------------------------
`default_nettype none

module dlfpl_datapath (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  dlfpl_pkg::t_cmd     i_cmd,
    output dlfpl_pkg::t_sts     o_sts,
    input  wire                 i_kind,
    input  dlfpl_pkg::t_id      i_page_id,
    input  wire                 i_cfg_valid,
    input  dlfpl_pkg::t_id      i_cfg_data,
    output dlfpl_pkg::t_id      o_head_page_id,
    output logic                o_list_empty,
    output dlfpl_pkg::t_id      o_page_done,
    output logic                o_done
);
    import dlfpl_pkg::*;

    t_id   r_null;
    t_id   r_head;
    t_id   n_head;
    t_id   r_page;
    t_id   r_out_head;
    logic  r_out_empty;
    t_id   r_out_page;
    logic  r_done;

    logic  prev_we;
    t_addr prev_waddr;
    t_id   prev_wdata;
    t_id   prev_rdata;
    logic  next_we;
    t_addr next_waddr;
    t_id   next_wdata;
    t_id   next_rdata;
    logic  rd_en;

    logic  head_ok;
    logic  pr_ok;
    logic  nx_ok;

    assign o_sts.id_ok = (i_page_id != r_null) && in_range(i_page_id);
    assign o_sts.kind  = i_kind;

    assign head_ok = (r_head != r_null) && in_range(r_head);
    assign pr_ok   = (prev_rdata != r_null) && in_range(prev_rdata);
    assign nx_ok   = (next_rdata != r_null) && in_range(next_rdata);

    always_comb begin
        prev_we    = 1'b0;
        prev_waddr = id_to_addr(r_page);
        prev_wdata = r_null;
        next_we    = 1'b0;
        next_waddr = id_to_addr(r_page);
        next_wdata = r_null;
        rd_en      = 1'b0;
        n_head     = r_head;
        unique case (i_cmd.op)
            OP_INS1: begin
                prev_we    = 1'b1;
                next_we    = 1'b1;
                next_wdata = r_head;
            end
            OP_INS2: begin
                prev_we    = head_ok;
                prev_waddr = id_to_addr(r_head);
                prev_wdata = r_page;
                n_head     = r_page;
            end
            OP_RM_RD: begin
                rd_en = 1'b1;
            end
            OP_RM_LINK: begin
                prev_we    = nx_ok;
                prev_waddr = id_to_addr(next_rdata);
                prev_wdata = prev_rdata;
                next_we    = pr_ok;
                next_waddr = id_to_addr(prev_rdata);
                next_wdata = next_rdata;
            end
            OP_RM_CLR: begin
                prev_we = 1'b1;
                next_we = 1'b1;
                if (r_head == r_page) begin
                    n_head = next_rdata;
                end
            end
            OP_NONE, OP_SKIP: begin
            end
            default: begin
            end
        endcase
    end

    dlfpl_ram #(
        .WIDTH(ID_W),
        .DEPTH(PAGES)
    ) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (prev_we),
        .i_waddr (prev_waddr),
        .i_wdata (prev_wdata),
        .i_re    (rd_en),
        .i_raddr (id_to_addr(r_page)),
        .o_rdata (prev_rdata)
    );

    dlfpl_ram #(
        .WIDTH(ID_W),
        .DEPTH(PAGES)
    ) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (next_we),
        .i_waddr (next_waddr),
        .i_wdata (next_wdata),
        .i_re    (rd_en),
        .i_raddr (id_to_addr(r_page)),
        .o_rdata (next_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_null <= '0;
            r_head <= '0;
            r_done <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_null <= i_cfg_data;
            end
            r_head <= n_head;
            r_done <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_page <= i_page_id;
        end
        if (i_cmd.finish) begin
            r_out_head  <= n_head;
            r_out_empty <= (n_head == r_null);
            r_out_page  <= r_page;
        end
    end

    assign o_head_page_id = r_out_head;
    assign o_list_empty   = r_out_empty;
    assign o_page_done    = r_out_page;
    assign o_done         = r_done;

endmodule

`default_nettype wire

// ----- rtl/dlfpl_ctrl.sv -----
// ---------------------------------------------------------------------------
// dlfpl_ctrl
// Sequencer for insert and remove requests on the link tables.
// ---------------------------------------------------------------------------
`default_nettype none

module dlfpl_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 start,
    output logic                busy,
    input  dlfpl_pkg::t_sts     i_sts,
    output dlfpl_pkg::t_cmd     o_cmd
);
    import dlfpl_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS1,
        S_INS2,
        S_RM_RD,
        S_RM_LINK,
        S_RM_CLR,
        S_SKIP
    } t_state;

    t_state r_state;
    logic   r_busy;
    logic   accept;

    assign accept = start && !r_busy;
    assign busy   = r_busy;

    always_comb begin
        o_cmd.load   = accept;
        o_cmd.finish = 1'b0;
        o_cmd.op     = OP_NONE;
        unique case (r_state)
            S_IDLE:    o_cmd.op = OP_NONE;
            S_INS1:    o_cmd.op = OP_INS1;
            S_INS2: begin
                o_cmd.op     = OP_INS2;
                o_cmd.finish = 1'b1;
            end
            S_RM_RD:   o_cmd.op = OP_RM_RD;
            S_RM_LINK: o_cmd.op = OP_RM_LINK;
            S_RM_CLR: begin
                o_cmd.op     = OP_RM_CLR;
                o_cmd.finish = 1'b1;
            end
            S_SKIP: begin
                o_cmd.op     = OP_SKIP;
                o_cmd.finish = 1'b1;
            end
            default:   o_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_busy <= 1'b1;
                        priority if (!i_sts.id_ok) begin
                            r_state <= S_SKIP;
                        end else if (i_sts.kind == KIND_REMOVE) begin
                            r_state <= S_RM_RD;
                        end else begin
                            r_state <= S_INS1;
                        end
                    end
                end
                S_INS1: begin
                    r_state <= S_INS2;
                end
                S_RM_RD: begin
                    r_state <= S_RM_LINK;
                end
                S_RM_LINK: begin
                    r_state <= S_RM_CLR;
                end
                S_INS2, S_RM_CLR, S_SKIP: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/doubly_linked_free_page_list.sv -----
// ---------------------------------------------------------------------------
// doubly_linked_free_page_list
// Free page list kept as previous and next link tables plus a head register.
// ---------------------------------------------------------------------------
// The result strobe follows each accepted request, whether its id is ignored,
// inserted or removed. Busy drops as the strobe rises, so a new request can be
// accepted while the strobe is high; an insert writes the page's own links and
// then, if the old head is live, its previous link, and a remove reads the links
// before it writes the neighbours and then the page itself. Reset clears the
// head and null id to zero and idles the sequencer; the tables are not cleared.
`default_nettype none

module doubly_linked_free_page_list (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 start,
    output logic                busy,
    input  wire                 i_kind,
    input  dlfpl_pkg::t_id      i_page_id,
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  dlfpl_pkg::t_id      i_cfg_data,
    output logic                o_done,
    output dlfpl_pkg::t_id      o_head_page_id,
    output logic                o_list_empty,
    output dlfpl_pkg::t_id      o_page_done
);
    import dlfpl_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    dlfpl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    dlfpl_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_kind         (i_kind),
        .i_page_id      (i_page_id),
        .i_cfg_valid    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_head_page_id (o_head_page_id),
        .o_list_empty   (o_list_empty),
        .o_page_done    (o_page_done),
        .o_done         (o_done)
    );

endmodule

`default_nettype wire

// ----- rtl/dlfpl_checker.sv -----
// ---------------------------------------------------------------------------
// dlfpl_checker
// Port-level checks of the request and result timing of the free page list.
// ---------------------------------------------------------------------------
`default_nettype none

module dlfpl_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 start,
    input wire                 busy,
    input wire                 o_done
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after an accepted request");

    a_done_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (!busy && $past(busy)))
        else $error("result strobe without the end of a busy period");

    a_busy_ends_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("busy period ended without a result");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

endmodule

bind doubly_linked_free_page_list dlfpl_checker u_dlfpl_checker (.*);

`default_nettype wire

// ----- test/tb_doubly_linked_free_page_list.sv -----
// ---------------------------------------------------------------------------
// tb_doubly_linked_free_page_list
// Self-checking bench for the free page list: directed and random insert and
// remove requests under several null id settings, each result compared with
// a predicted head, empty flag and page id.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_doubly_linked_free_page_list;

    import dlfpl_pkg::*;

    localparam int STALL_LIMIT = 2000;

    typedef struct {
        t_id  head;
        logic empty;
        t_id  page;
    } list_result_t;

    class free_list_scoreboard;
        t_id          null_id;
        t_id          head_id;
        t_id          prev_link [PAGES];
        t_id          next_link [PAGES];
        bit           prev_set  [PAGES];
        bit           next_set  [PAGES];
        list_result_t awaited_results [$];
        int           errors;

        function new();
            null_id = '0;
            head_id = '0;
            errors  = 0;
        endfunction

        function bit can_remove(t_id page);
            return prev_set[page] && next_set[page];
        endfunction

        function bit live_link(t_id id);
            return id != null_id && int'(id) < PAGES;
        endfunction

        function void note_request(logic kind, t_id page);
            t_id          pr;
            t_id          nx;
            list_result_t res;
            if (page != null_id && int'(page) < PAGES) begin
                if (kind == KIND_INSERT) begin
                    prev_link[page] = null_id;
                    prev_set[page]  = 1'b1;
                    if (live_link(head_id)) begin
                        prev_link[head_id] = page;
                        prev_set[head_id]  = 1'b1;
                    end
                    next_link[page] = head_id;
                    next_set[page]  = 1'b1;
                    head_id         = page;
                end else begin
                    pr = prev_link[page];
                    nx = next_link[page];
                    if (live_link(pr)) begin
                        next_link[pr] = nx;
                        next_set[pr]  = 1'b1;
                    end
                    if (live_link(nx)) begin
                        prev_link[nx] = pr;
                        prev_set[nx]  = 1'b1;
                    end
                    prev_link[page] = null_id;
                    next_link[page] = null_id;
                    prev_set[page]  = 1'b1;
                    next_set[page]  = 1'b1;
                    if (head_id == page) begin
                        head_id = nx;
                    end
                end
            end
            res.head  = head_id;
            res.empty = (head_id == null_id);
            res.page  = page;
            awaited_results.push_back(res);
        endfunction

        function void check_result(t_id head, logic empty, t_id page);
            list_result_t exp;
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected result head %0d empty %0d page %0d",
                         $time, head, empty, page);
                errors++;
                return;
            end
            exp = awaited_results.pop_front();
            if (head !== exp.head) begin
                $display("%0t: head_page_id expected %0d actual %0d",
                         $time, exp.head, head);
                errors++;
            end
            if (empty !== exp.empty) begin
                $display("%0t: list_empty expected %0d actual %0d",
                         $time, exp.empty, empty);
                errors++;
            end
            if (page !== exp.page) begin
                $display("%0t: page_done expected %0d actual %0d",
                         $time, exp.page, page);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic start;
    logic busy;
    logic i_kind;
    t_id  i_page_id;
    logic i_cfg_valid;
    logic o_cfg_ready;
    t_id  i_cfg_data;
    logic o_done;
    t_id  o_head_page_id;
    logic o_list_empty;
    t_id  o_page_done;

    free_list_scoreboard board = new();

    bit  in_list [PAGES];
    t_id members [$];
    int  gap_pct;
    int  stall_cycles;

    doubly_linked_free_page_list dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_kind         (i_kind),
        .i_page_id      (i_page_id),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_done         (o_done),
        .o_head_page_id (o_head_page_id),
        .o_list_empty   (o_list_empty),
        .o_page_done    (o_page_done)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            board.check_result(o_head_page_id, o_list_empty, o_page_done);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
        end
        $display("DONE: errors detected");
        $finish;
    end

    task automatic issue(input logic kind, input t_id page);
        int idx;
        while ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start     <= 1'b1;
        i_kind    <= kind;
        i_page_id <= page;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        board.note_request(kind, page);
        if (page != board.null_id) begin
            if (kind == KIND_INSERT && !in_list[page]) begin
                in_list[page] = 1'b1;
                members.push_back(page);
            end else if (kind == KIND_REMOVE && in_list[page]) begin
                in_list[page] = 1'b0;
                idx = 0;
                foreach (members[j]) begin
                    if (members[j] == page) begin
                        idx = j;
                    end
                end
                members.delete(idx);
            end
        end
    endtask

    task automatic write_null_id(input t_id value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid   <= 1'b0;
        board.null_id = value;
    endtask

    task automatic drain();
        while (board.awaited_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (6) @(posedge i_clk);
    endtask

    task automatic run_phase(input int count, input int pct);
        int  r;
        int  tries;
        t_id p;
        gap_pct = pct;
        repeat (count) begin
            r = $urandom_range(99);
            if (r < 45) begin
                p = t_id'($urandom_range(PAGES - 1));
                tries = 0;
                while (in_list[p] && tries < 8) begin
                    p = t_id'($urandom_range(PAGES - 1));
                    tries++;
                end
                issue(KIND_INSERT, p);
            end else if (r < 85 && members.size() != 0) begin
                issue(KIND_REMOVE, members[$urandom_range(members.size() - 1)]);
            end else if (r < 88) begin
                issue(KIND_INSERT, board.head_id);
            end else if (r < 92) begin
                issue(KIND_INSERT, t_id'($urandom_range(PAGES - 1)));
            end else if (r < 97) begin
                p = t_id'($urandom_range(PAGES - 1));
                tries = 0;
                while ((in_list[p] || !board.can_remove(p)) && tries < 16) begin
                    p = t_id'($urandom_range(PAGES - 1));
                    tries++;
                end
                if (board.can_remove(p)) begin
                    issue(KIND_REMOVE, p);
                end else begin
                    issue(KIND_INSERT, p);
                end
            end else begin
                issue(logic'($urandom_range(1)), board.null_id);
            end
        end
        start <= 1'b0;
    endtask

    initial begin
        start       <= 1'b0;
        i_kind      <= KIND_INSERT;
        i_page_id   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        i_rst_n     <= 1'b0;
        gap_pct     = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_null_id('0);

        // Null id requests, middle, tail and head removal, re-insert of the head.
        gap_pct = 9;
        issue(KIND_INSERT, 10'd0);
        issue(KIND_REMOVE, 10'd0);
        issue(KIND_INSERT, 10'd1023);
        issue(KIND_INSERT, 10'd1);
        issue(KIND_INSERT, 10'd512);
        issue(KIND_REMOVE, 10'd1);
        issue(KIND_REMOVE, 10'd1023);
        issue(KIND_INSERT, 10'd700);
        issue(KIND_REMOVE, 10'd700);
        issue(KIND_REMOVE, 10'd512);
        issue(KIND_REMOVE, 10'd1);
        issue(KIND_INSERT, 10'd682);
        issue(KIND_INSERT, 10'd341);
        issue(KIND_REMOVE, 10'd341);
        issue(KIND_REMOVE, 10'd682);
        issue(KIND_INSERT, 10'd3);
        issue(KIND_INSERT, 10'd3);
        issue(KIND_REMOVE, 10'd3);
        issue(KIND_INSERT, 10'd4);
        issue(KIND_REMOVE, 10'd4);
        issue(KIND_REMOVE, 10'd3);

        run_phase(300, 9);
        drain();
        write_null_id(10'h3FF);
        run_phase(300, 65);
        drain();
        write_null_id(t_id'($urandom_range(PAGES - 2, 1)));
        run_phase(300, 0);
        drain();

        if (board.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
